### sv/tmse_pkg.sv
// Shared types, codes and defaults for the Turing machine step engine.
package tmse_pkg;

    localparam int NUM_STATES_DEF      = 16;
    localparam int RULES_PER_STATE_DEF = 8;
    localparam int TAPE_LEN_DEF        = 1024;

    localparam int INIT_STATE_RST   = 0;
    localparam int TAPE_ORIGIN_RST  = 512;
    localparam int BLANK_SYMBOL_RST = 32;

    typedef enum logic [1:0] {
        ACT_LOAD_RULE,
        ACT_LOAD_CELL,
        ACT_START,
        ACT_STEP
    } action_t;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_LEFT,
        DIR_STAY,
        DIR_BAD
    } dir_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_BAD_DIR,
        ERR_UNDEF_STATE,
        ERR_NO_RULE,
        ERR_TAPE_FULL
    } err_t;

    typedef enum logic [1:0] {
        CFG_INIT_STATE,
        CFG_TAPE_ORIGIN,
        CFG_BLANK_SYMBOL
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] match_symbol;
        logic       match_any;
        logic [7:0] put_symbol;
        logic       put_keep;
        dir_t       direction;
        logic [3:0] next_state;
        logic       next_halts;
    } rule_t;

endpackage

### sv/tmse_rule_mem.sv
// Rule table memory with per-entry valid bits and registered read.
module tmse_rule_mem #(
    parameter int NUM_STATES      = tmse_pkg::NUM_STATES_DEF,
    parameter int RULES_PER_STATE = tmse_pkg::RULES_PER_STATE_DEF,
    localparam int DEPTH          = NUM_STATES * RULES_PER_STATE,
    localparam int RAW            = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic [RAW-1:0]  wr_addr,
    input  tmse_pkg::rule_t wr_data,
    input  logic [RAW-1:0]  rd_addr,
    output tmse_pkg::rule_t rd_data,
    output logic            rd_valid
);

    tmse_pkg::rule_t mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    tmse_pkg::rule_t  rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

### sv/tmse_tape_mem.sv
// Tape cell memory, one write and one registered read per cycle.
module tmse_tape_mem #(
    parameter int TAPE_LEN = tmse_pkg::TAPE_LEN_DEF,
    localparam int AW      = $clog2(TAPE_LEN)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [TAPE_LEN];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/turing_machine_step_engine_top.sv
// Turing machine step engine: sequencer, position unit and result register.
// Rule load: the result goes out through the read and output states. Step: a scan of the
// rule memory, one slot per cycle, then execute and, if the tape grows, one blank write.
// Tape load and start: TAPE_LEN is subtracted from the origin until it fits, then blank
// cells are added to the tape one at a time; a cell past the tape end is not written.
// Reset: the init state writes the blank symbol into the origin cell; items wait for it.
module turing_machine_step_engine_top #(
    parameter int NUM_STATES      = tmse_pkg::NUM_STATES_DEF,
    parameter int RULES_PER_STATE = tmse_pkg::RULES_PER_STATE_DEF,
    parameter int TAPE_LEN        = tmse_pkg::TAPE_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [3:0]  rule_state,
    input  logic [2:0]  rule_slot,
    input  logic [7:0]  match_symbol,
    input  logic        match_any,
    input  logic [7:0]  put_symbol,
    input  logic        put_keep,
    input  logic [1:0]  direction,
    input  logic [3:0]  next_state,
    input  logic        next_halts,
    input  logic [9:0]  cell_index,
    input  logic [7:0]  cell_symbol,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  current_state_out,
    output logic [9:0]  head_offset,
    output logic [7:0]  symbol_under_head,
    output logic [10:0] tape_length,
    output logic        halted,
    output logic [2:0]  error_code,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int AW          = $clog2(TAPE_LEN);
    localparam int SW          = $clog2(NUM_STATES);
    localparam int RAW         = $clog2(NUM_STATES * RULES_PER_STATE);
    localparam int KCW         = $clog2(RULES_PER_STATE + 1);
    localparam int XW          = ((AW > 10) ? AW : 10) + 2;
    localparam int ORIGIN_CELL = tmse_pkg::TAPE_ORIGIN_RST % TAPE_LEN;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ORG,
        ST_COVER,
        ST_SCAN,
        ST_EXEC,
        ST_EXT,
        ST_RD,
        ST_OUT
    } seq_state_t;

    seq_state_t        state_reg;
    tmse_pkg::action_t act_reg;
    logic [9:0]        cell_index_reg;
    logic [7:0]        cell_symbol_reg;
    logic [3:0]        init_state_reg;
    logic [9:0]        tape_origin_reg;
    logic [7:0]        blank_symbol_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     left_reg;
    logic [AW-1:0]     right_reg;
    logic [3:0]        cur_state_reg;
    logic              halt_reg;
    tmse_pkg::err_t    err_reg;
    logic [NUM_STATES-1:0] state_def_reg;
    logic [XW-1:0]     org_reg;
    logic [AW-1:0]     tgt_reg;
    logic [KCW-1:0]    iss_cnt_reg;
    logic              ev_v_reg;
    logic              ev_last_reg;
    logic              wild_v_reg;
    tmse_pkg::rule_t   wild_reg;
    tmse_pkg::rule_t   hit_reg;
    logic              out_valid_reg;
    logic [3:0]        out_state_reg;
    logic [9:0]        out_offset_reg;
    logic [7:0]        out_symbol_reg;
    logic [10:0]       out_length_reg;
    logic              out_halted_reg;
    logic [2:0]        out_error_reg;

    logic            accept;
    logic            out_load;
    logic [SW-1:0]   wr_ridx;
    logic [SW-1:0]   cur_idx;
    logic            rule_ok;
    logic            rule_wr_en;
    logic [RAW-1:0]  rule_wr_addr;
    tmse_pkg::rule_t rule_wr_data;
    logic [RAW-1:0]  rule_rd_addr;
    tmse_pkg::rule_t ent;
    logic            ent_raw_v;
    logic [7:0]      sym;
    logic            ent_v;
    logic            exact;
    logic            ent_wild;
    logic            org_ge;
    logic [XW-1:0]   tgt_sum;
    logic            tgt_fits;
    logic            below;
    logic            above;
    logic            tw_en;
    logic [AW-1:0]   tw_addr;
    logic [7:0]      tw_data;
    logic [AW-1:0]   mv_head;
    logic [AW-1:0]   mv_left;
    logic [AW-1:0]   mv_right;
    logic            mv_ext;
    tmse_pkg::err_t  mv_err;
    logic            nx_ok;
    logic [XW-1:0]   off_x;
    logic [XW-1:0]   len_x;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // rule memory ports
    assign wr_ridx      = SW'(rule_state);
    assign cur_idx      = SW'(cur_state_reg);
    assign rule_ok      = (32'(rule_state) < NUM_STATES) && (32'(rule_slot) < RULES_PER_STATE);
    assign rule_wr_en   = accept && (tmse_pkg::action_t'(action) == tmse_pkg::ACT_LOAD_RULE)
                          && rule_ok;
    assign rule_wr_addr = RAW'(32'(wr_ridx) * RULES_PER_STATE + 32'(rule_slot));
    assign rule_rd_addr = RAW'(32'(cur_idx) * RULES_PER_STATE + 32'(iss_cnt_reg));
    assign rule_wr_data = '{
        match_symbol: match_symbol,
        match_any:    match_any,
        put_symbol:   put_symbol,
        put_keep:     put_keep,
        direction:    tmse_pkg::dir_t'(direction),
        next_state:   next_state,
        next_halts:   next_halts
    };

    tmse_rule_mem #(
        .NUM_STATES      (NUM_STATES),
        .RULES_PER_STATE (RULES_PER_STATE)
    ) u_rule_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (rule_wr_en),
        .wr_addr  (rule_wr_addr),
        .wr_data  (rule_wr_data),
        .rd_addr  (rule_rd_addr),
        .rd_data  (ent),
        .rd_valid (ent_raw_v)
    );

    tmse_tape_mem #(
        .TAPE_LEN (TAPE_LEN)
    ) u_tape_mem (
        .clk     (clk),
        .wr_en   (tw_en),
        .wr_addr (tw_addr),
        .wr_data (tw_data),
        .rd_addr (head_reg),
        .rd_data (sym)
    );

    // scan evaluation, one slot per cycle
    assign ent_v    = ev_v_reg && ent_raw_v;
    assign exact    = ent_v && !ent.match_any && (ent.match_symbol == sym);
    assign ent_wild = ent_v && ent.match_any;

    // origin reduction and tape extent
    assign org_ge   = org_reg >= XW'(TAPE_LEN);
    assign tgt_sum  = org_reg + ((act_reg == tmse_pkg::ACT_LOAD_CELL) ?
                                 XW'(cell_index_reg) : '0);
    assign tgt_fits = tgt_sum < XW'(TAPE_LEN);
    assign below    = tgt_reg < left_reg;
    assign above    = tgt_reg > right_reg;

    assign off_x = XW'(head_reg) - XW'(left_reg);
    assign len_x = XW'(right_reg) - XW'(left_reg) + XW'(1);

    always_comb
    begin
        mv_head  = head_reg;
        mv_left  = left_reg;
        mv_right = right_reg;
        mv_ext   = 1'b0;
        mv_err   = tmse_pkg::ERR_NONE;
        case (hit_reg.direction)
            tmse_pkg::DIR_RIGHT:
            begin
                if (head_reg < right_reg)
                begin
                    mv_head = head_reg + AW'(1);
                end
                else if (right_reg != AW'(TAPE_LEN - 1))
                begin
                    mv_right = right_reg + AW'(1);
                    mv_head  = right_reg + AW'(1);
                    mv_ext   = 1'b1;
                end
                else
                begin
                    mv_err = tmse_pkg::ERR_TAPE_FULL;
                end
            end
            tmse_pkg::DIR_LEFT:
            begin
                if (head_reg > left_reg)
                begin
                    mv_head = head_reg - AW'(1);
                end
                else if (left_reg != '0)
                begin
                    mv_left = left_reg - AW'(1);
                    mv_head = left_reg - AW'(1);
                    mv_ext  = 1'b1;
                end
                else
                begin
                    mv_err = tmse_pkg::ERR_TAPE_FULL;
                end
            end
            tmse_pkg::DIR_STAY:
            begin
                mv_err = tmse_pkg::ERR_NONE;
            end
            default:
            begin
                mv_err = tmse_pkg::ERR_BAD_DIR;
            end
        endcase
        nx_ok = (32'(hit_reg.next_state) < NUM_STATES)
                && state_def_reg[SW'(hit_reg.next_state)];
        if (!hit_reg.next_halts && !nx_ok)
        begin
            mv_err = tmse_pkg::ERR_UNDEF_STATE;
        end
    end

    // tape write port
    always_comb
    begin
        tw_en   = 1'b0;
        tw_addr = head_reg;
        tw_data = blank_symbol_reg;
        case (state_reg)
            ST_INIT:
            begin
                tw_en   = 1'b1;
                tw_addr = AW'(ORIGIN_CELL);
                tw_data = 8'(tmse_pkg::BLANK_SYMBOL_RST);
            end
            ST_COVER:
            begin
                if (below)
                begin
                    tw_en   = 1'b1;
                    tw_addr = left_reg - AW'(1);
                end
                else if (above)
                begin
                    tw_en   = 1'b1;
                    tw_addr = right_reg + AW'(1);
                end
                else if (act_reg == tmse_pkg::ACT_LOAD_CELL)
                begin
                    tw_en   = 1'b1;
                    tw_addr = tgt_reg;
                    tw_data = cell_symbol_reg;
                end
            end
            ST_EXEC:
            begin
                tw_en   = !hit_reg.put_keep;
                tw_data = hit_reg.put_symbol;
            end
            ST_EXT:
            begin
                tw_en = 1'b1;
            end
            default:
            begin
                tw_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            init_state_reg   <= 4'(tmse_pkg::INIT_STATE_RST);
            tape_origin_reg  <= 10'(tmse_pkg::TAPE_ORIGIN_RST);
            blank_symbol_reg <= 8'(tmse_pkg::BLANK_SYMBOL_RST);
            head_reg         <= AW'(ORIGIN_CELL);
            left_reg         <= AW'(ORIGIN_CELL);
            right_reg        <= AW'(ORIGIN_CELL);
            cur_state_reg    <= 4'(tmse_pkg::INIT_STATE_RST);
            halt_reg         <= 1'b0;
            err_reg          <= tmse_pkg::ERR_NONE;
            state_def_reg    <= '0;
            iss_cnt_reg      <= '0;
            ev_v_reg         <= 1'b0;
            ev_last_reg      <= 1'b0;
            wild_v_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (tmse_pkg::cfg_idx_t'(cfg_index))
                    tmse_pkg::CFG_INIT_STATE:   init_state_reg   <= cfg_data[3:0];
                    tmse_pkg::CFG_TAPE_ORIGIN:  tape_origin_reg  <= cfg_data;
                    tmse_pkg::CFG_BLANK_SYMBOL: blank_symbol_reg <= cfg_data[7:0];
                    default:                    ;
                endcase
            end

            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_INIT:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (tmse_pkg::action_t'(action))
                            tmse_pkg::ACT_LOAD_RULE:
                            begin
                                if (rule_ok)
                                begin
                                    state_def_reg[wr_ridx] <= 1'b1;
                                end
                                state_reg <= ST_RD;
                            end
                            tmse_pkg::ACT_STEP:
                            begin
                                if (halt_reg || (err_reg != tmse_pkg::ERR_NONE)
                                    || (32'(cur_state_reg) >= NUM_STATES))
                                begin
                                    state_reg <= ST_RD;
                                end
                                else
                                begin
                                    state_reg   <= ST_SCAN;
                                    iss_cnt_reg <= '0;
                                    ev_v_reg    <= 1'b0;
                                    wild_v_reg  <= 1'b0;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_ORG;
                            end
                        endcase
                    end
                end
                ST_ORG:
                begin
                    if (!org_ge)
                    begin
                        state_reg <= tgt_fits ? ST_COVER : ST_RD;
                    end
                end
                ST_COVER:
                begin
                    if (below)
                    begin
                        left_reg <= left_reg - AW'(1);
                    end
                    else if (above)
                    begin
                        right_reg <= right_reg + AW'(1);
                    end
                    else
                    begin
                        if (act_reg == tmse_pkg::ACT_START)
                        begin
                            head_reg      <= tgt_reg;
                            cur_state_reg <= init_state_reg;
                            halt_reg      <= 1'b0;
                            err_reg       <= tmse_pkg::ERR_NONE;
                        end
                        state_reg <= ST_RD;
                    end
                end
                ST_SCAN:
                begin
                    if (32'(iss_cnt_reg) < RULES_PER_STATE)
                    begin
                        iss_cnt_reg <= iss_cnt_reg + KCW'(1);
                        ev_v_reg    <= 1'b1;
                        ev_last_reg <= (32'(iss_cnt_reg) == RULES_PER_STATE - 1);
                    end
                    else
                    begin
                        ev_v_reg <= 1'b0;
                    end
                    if (ent_wild)
                    begin
                        wild_v_reg <= 1'b1;
                    end
                    if (exact)
                    begin
                        state_reg <= ST_EXEC;
                    end
                    else if (ev_v_reg && ev_last_reg)
                    begin
                        if (ent_wild || wild_v_reg)
                        begin
                            state_reg <= ST_EXEC;
                        end
                        else
                        begin
                            err_reg   <= tmse_pkg::ERR_NO_RULE;
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_EXEC:
                begin
                    head_reg  <= mv_head;
                    left_reg  <= mv_left;
                    right_reg <= mv_right;
                    if (mv_err != tmse_pkg::ERR_NONE)
                    begin
                        err_reg <= mv_err;
                    end
                    else
                    begin
                        cur_state_reg <= hit_reg.next_state;
                        if (hit_reg.next_halts)
                        begin
                            halt_reg <= 1'b1;
                        end
                    end
                    state_reg <= mv_ext ? ST_EXT : ST_RD;
                end
                ST_EXT:
                begin
                    state_reg <= ST_RD;
                end
                ST_RD:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg         <= tmse_pkg::action_t'(action);
            cell_index_reg  <= cell_index;
            cell_symbol_reg <= cell_symbol;
            org_reg         <= XW'(tape_origin_reg);
        end
        if (state_reg == ST_ORG)
        begin
            if (org_ge)
            begin
                org_reg <= org_reg - XW'(TAPE_LEN);
            end
            else
            begin
                tgt_reg <= tgt_sum[AW-1:0];
            end
        end
        if (state_reg == ST_SCAN)
        begin
            if (ent_wild)
            begin
                wild_reg <= ent;
            end
            if (exact)
            begin
                hit_reg <= ent;
            end
            else if (ev_v_reg && ev_last_reg)
            begin
                hit_reg <= ent_wild ? ent : wild_reg;
            end
        end
        if (out_load)
        begin
            out_state_reg  <= cur_state_reg;
            out_offset_reg <= off_x[9:0];
            out_symbol_reg <= sym;
            out_length_reg <= len_x[10:0];
            out_halted_reg <= halt_reg;
            out_error_reg  <= 3'(err_reg);
        end
    end

    assign out_valid         = out_valid_reg;
    assign current_state_out = out_state_reg;
    assign head_offset       = out_offset_reg;
    assign symbol_under_head = out_symbol_reg;
    assign tape_length       = out_length_reg;
    assign halted            = out_halted_reg;
    assign error_code        = out_error_reg;

    a_head_in_tape: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg <= head_reg) && (head_reg <= right_reg))
        else $error("head outside used tape");

    a_halt_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(halt_reg && (err_reg != tmse_pkg::ERR_NONE)))
        else $error("halt and error both set");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input not held off after transfer");

    a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("result not presented");

endmodule

### tb/turing_machine_step_engine_top_tb.sv
// Self-checking testbench for the Turing machine step engine: directed and random programs.
module turing_machine_step_engine_top_tb;

    localparam int RUN_LIMIT = 20 * 1000000;

    typedef struct {
        tmse_pkg::action_t act;
        logic [3:0]        rule_state;
        logic [2:0]        rule_slot;
        logic [7:0]        match_symbol;
        logic              match_any;
        logic [7:0]        put_symbol;
        logic              put_keep;
        tmse_pkg::dir_t    direction;
        logic [3:0]        next_state;
        logic              next_halts;
        logic [9:0]        cell_index;
        logic [7:0]        cell_symbol;
    } tm_item_t;

    typedef struct {
        logic [3:0]     state;
        logic [9:0]     offset;
        logic [7:0]     symbol;
        logic [10:0]    length;
        logic           halted;
        tmse_pkg::err_t err;
    } tm_status_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [3:0]  rule_state;
    logic [2:0]  rule_slot;
    logic [7:0]  match_symbol;
    logic        match_any;
    logic [7:0]  put_symbol;
    logic        put_keep;
    logic [1:0]  direction;
    logic [3:0]  next_state;
    logic        next_halts;
    logic [9:0]  cell_index;
    logic [7:0]  cell_symbol;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  current_state_out;
    logic [9:0]  head_offset;
    logic [7:0]  symbol_under_head;
    logic [10:0] tape_length;
    logic        halted;
    logic [2:0]  error_code;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_data;

    // machine image
    tmse_pkg::rule_t rule_mem [tmse_pkg::NUM_STATES_DEF][tmse_pkg::RULES_PER_STATE_DEF];
    bit              rule_ok [tmse_pkg::NUM_STATES_DEF][tmse_pkg::RULES_PER_STATE_DEF];
    bit              state_used [tmse_pkg::NUM_STATES_DEF];
    logic [7:0]      tape_img [tmse_pkg::TAPE_LEN_DEF];
    int              head_pos;
    int              left_end;
    int              right_end;
    logic [3:0]      cur_state;
    bit              halt_seen;
    tmse_pkg::err_t  fault;
    logic [3:0]      cfg_init;
    logic [9:0]      cfg_origin;
    logic [7:0]      cfg_blank;

    tm_status_t pending_status [$];
    int         mismatch_count = 0;
    int         items_sent = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;
    logic       hold_out = 1'b0;

    turing_machine_step_engine_top i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("status: fail");
        $finish;
    end

    function automatic void reset_machine();
        for (int s = 0; s < tmse_pkg::NUM_STATES_DEF; s++)
        begin
            state_used[s] = 1'b0;
            for (int k = 0; k < tmse_pkg::RULES_PER_STATE_DEF; k++)
                rule_ok[s][k] = 1'b0;
        end
        cfg_init   = 4'(tmse_pkg::INIT_STATE_RST);
        cfg_origin = 10'(tmse_pkg::TAPE_ORIGIN_RST);
        cfg_blank  = 8'(tmse_pkg::BLANK_SYMBOL_RST);
        head_pos   = int'(cfg_origin);
        left_end   = head_pos;
        right_end  = head_pos;
        tape_img[head_pos] = cfg_blank;
        cur_state  = cfg_init;
        halt_seen  = 1'b0;
        fault      = tmse_pkg::ERR_NONE;
    endfunction

    function automatic void grow_tape(int p);
        while (p < left_end)
        begin
            left_end--;
            tape_img[left_end] = cfg_blank;
        end
        while (p > right_end)
        begin
            right_end++;
            tape_img[right_end] = cfg_blank;
        end
    endfunction

    function automatic void run_step();
        int              hit;
        int              wild;
        logic [7:0]      sym;
        tmse_pkg::rule_t r;
        tmse_pkg::err_t  e;
        if (halt_seen || fault != tmse_pkg::ERR_NONE)
            return;
        sym  = tape_img[head_pos];
        hit  = -1;
        wild = -1;
        for (int k = 0; k < tmse_pkg::RULES_PER_STATE_DEF; k++)
        begin
            if (rule_ok[cur_state][k])
            begin
                if (rule_mem[cur_state][k].match_any)
                    wild = k;
                else if (rule_mem[cur_state][k].match_symbol == sym)
                begin
                    hit = k;
                    break;
                end
            end
        end
        if (hit < 0)
            hit = wild;
        if (hit < 0)
        begin
            fault = tmse_pkg::ERR_NO_RULE;
            return;
        end
        r = rule_mem[cur_state][hit];
        e = tmse_pkg::ERR_NONE;
        if (!r.put_keep)
            tape_img[head_pos] = r.put_symbol;
        case (r.direction)
            tmse_pkg::DIR_RIGHT:
            begin
                if (head_pos < right_end)
                    head_pos++;
                else if (right_end + 1 < tmse_pkg::TAPE_LEN_DEF)
                begin
                    right_end++;
                    tape_img[right_end] = cfg_blank;
                    head_pos = right_end;
                end
                else
                    e = tmse_pkg::ERR_TAPE_FULL;
            end
            tmse_pkg::DIR_LEFT:
            begin
                if (head_pos > left_end)
                    head_pos--;
                else if (left_end > 0)
                begin
                    left_end--;
                    tape_img[left_end] = cfg_blank;
                    head_pos = left_end;
                end
                else
                    e = tmse_pkg::ERR_TAPE_FULL;
            end
            tmse_pkg::DIR_STAY: ;
            default: e = tmse_pkg::ERR_BAD_DIR;
        endcase
        if (!r.next_halts && !state_used[r.next_state])
            e = tmse_pkg::ERR_UNDEF_STATE;
        if (e != tmse_pkg::ERR_NONE)
        begin
            fault = e;
            return;
        end
        cur_state = r.next_state;
        if (r.next_halts)
            halt_seen = 1'b1;
    endfunction

    function automatic tm_status_t predict_machine(tm_item_t it);
        tm_status_t st;
        int         p;
        case (it.act)
            tmse_pkg::ACT_LOAD_RULE:
            begin
                rule_mem[it.rule_state][it.rule_slot].match_symbol = it.match_symbol;
                rule_mem[it.rule_state][it.rule_slot].match_any    = it.match_any;
                rule_mem[it.rule_state][it.rule_slot].put_symbol   = it.put_symbol;
                rule_mem[it.rule_state][it.rule_slot].put_keep     = it.put_keep;
                rule_mem[it.rule_state][it.rule_slot].direction    = it.direction;
                rule_mem[it.rule_state][it.rule_slot].next_state   = it.next_state;
                rule_mem[it.rule_state][it.rule_slot].next_halts   = it.next_halts;
                rule_ok[it.rule_state][it.rule_slot] = 1'b1;
                state_used[it.rule_state] = 1'b1;
            end
            tmse_pkg::ACT_LOAD_CELL:
            begin
                p = int'(cfg_origin) + int'(it.cell_index);
                if (p < tmse_pkg::TAPE_LEN_DEF)
                begin
                    grow_tape(p);
                    tape_img[p] = it.cell_symbol;
                end
            end
            tmse_pkg::ACT_START:
            begin
                grow_tape(int'(cfg_origin));
                head_pos  = int'(cfg_origin);
                cur_state = cfg_init;
                halt_seen = 1'b0;
                fault     = tmse_pkg::ERR_NONE;
            end
            default: run_step();
        endcase
        st.state  = cur_state;
        st.offset = 10'(head_pos - left_end);
        st.symbol = tape_img[head_pos];
        st.length = 11'(right_end - left_end + 1);
        st.halted = halt_seen;
        st.err    = fault;
        return st;
    endfunction

    function automatic tm_item_t noise_item();
        tm_item_t it;
        it.act          = tmse_pkg::action_t'($urandom_range(0, 3));
        it.rule_state   = 4'($urandom);
        it.rule_slot    = 3'($urandom);
        it.match_symbol = 8'($urandom);
        it.match_any    = 1'($urandom);
        it.put_symbol   = 8'($urandom);
        it.put_keep     = 1'($urandom);
        it.direction    = tmse_pkg::dir_t'($urandom_range(0, 3));
        it.next_state   = 4'($urandom);
        it.next_halts   = 1'($urandom);
        it.cell_index   = 10'($urandom);
        it.cell_symbol  = 8'($urandom);
        return it;
    endfunction

    function automatic tm_item_t cmd_item(tmse_pkg::action_t a);
        tm_item_t it;
        it     = noise_item();
        it.act = a;
        return it;
    endfunction

    function automatic tm_item_t cell_item(logic [9:0] idx, logic [7:0] sym);
        tm_item_t it;
        it             = cmd_item(tmse_pkg::ACT_LOAD_CELL);
        it.cell_index  = idx;
        it.cell_symbol = sym;
        return it;
    endfunction

    function automatic tm_item_t rule_item(logic [3:0] st, logic [2:0] slot, logic any,
                                           logic [7:0] msym, logic keep, logic [7:0] psym,
                                           tmse_pkg::dir_t dir, logic [3:0] nxt,
                                           logic halts);
        tm_item_t it;
        it              = cmd_item(tmse_pkg::ACT_LOAD_RULE);
        it.rule_state   = st;
        it.rule_slot    = slot;
        it.match_any    = any;
        it.match_symbol = msym;
        it.put_keep     = keep;
        it.put_symbol   = psym;
        it.direction    = dir;
        it.next_state   = nxt;
        it.next_halts   = halts;
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic send_item(input tm_item_t it);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid     <= 1'b1;
        action       <= it.act;
        rule_state   <= it.rule_state;
        rule_slot    <= it.rule_slot;
        match_symbol <= it.match_symbol;
        match_any    <= it.match_any;
        put_symbol   <= it.put_symbol;
        put_keep     <= it.put_keep;
        direction    <= it.direction;
        next_state   <= it.next_state;
        next_halts   <= it.next_halts;
        cell_index   <= it.cell_index;
        cell_symbol  <= it.cell_symbol;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        pending_status.insert(pending_status.size(), predict_machine(it));
        items_sent++;
    endtask

    task automatic settle_results(input int settle);
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_status.size() != 0 && waited < 50000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_config(input logic [3:0] init, input logic [9:0] origin,
                              input logic [7:0] blank);
        settle_results(8);
        cfg_wr_en <= 1'b1;
        cfg_index <= tmse_pkg::CFG_INIT_STATE;
        cfg_data  <= 10'(init);
        @(posedge clk);
        cfg_index <= tmse_pkg::CFG_TAPE_ORIGIN;
        cfg_data  <= origin;
        @(posedge clk);
        cfg_index <= tmse_pkg::CFG_BLANK_SYMBOL;
        cfg_data  <= 10'(blank);
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        cfg_init   = init;
        cfg_origin = origin;
        cfg_blank  = blank;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        gap_pct   = send_pct;
        stall_pct = recv_pct;
    endtask

    task automatic hold_results(input int cycles);
        hold_out <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_out <= 1'b0;
    endtask

    // loads a small rule set and tape, starts, and steps until halt, error or a random step limit
    task automatic run_program();
        logic [3:0]     states [4];
        logic [7:0]     alphabet [4];
        int             n_states;
        int             n_steps;
        int             i;
        int             j;
        int             r;
        tmse_pkg::dir_t dir;
        n_states = $urandom_range(1, 4);
        states[0] = cfg_init;
        for (i = 1; i < n_states; i++)
            states[i] = 4'($urandom_range(0, 12));
        alphabet[0] = cfg_blank;
        for (i = 1; i < 4; i++)
            alphabet[i] = 8'($urandom);
        for (i = 0; i < n_states; i++)
        begin
            for (j = $urandom_range(1, 4); j > 0; j--)
            begin
                r = $urandom_range(99);
                dir = (r < 40) ? tmse_pkg::DIR_RIGHT :
                      (r < 80) ? tmse_pkg::DIR_LEFT :
                      (r < 96) ? tmse_pkg::DIR_STAY : tmse_pkg::DIR_BAD;
                send_item(rule_item(states[i], 3'($urandom), ($urandom_range(99) < 20),
                    ($urandom_range(99) < 90) ? alphabet[$urandom_range(0, 3)] : 8'($urandom),
                    ($urandom_range(99) < 15),
                    ($urandom_range(99) < 80) ? alphabet[$urandom_range(0, 3)] : 8'($urandom),
                    dir,
                    ($urandom_range(99) < 92) ? states[$urandom_range(0, n_states - 1)]
                                              : 4'($urandom),
                    ($urandom_range(99) < 6)));
            end
        end
        for (i = $urandom_range(0, 6); i > 0; i--)
            send_item(cell_item(($urandom_range(99) < 5) ? 10'($urandom)
                                                         : 10'($urandom_range(0, 15)),
                                alphabet[$urandom_range(0, 3)]));
        send_item(cmd_item(tmse_pkg::ACT_START));
        n_steps = $urandom_range(5, 40);
        for (i = 0; i < n_steps && !halt_seen && fault == tmse_pkg::ERR_NONE; i++)
        begin
            if ($urandom_range(99) < 4)
                send_item(noise_item());
            else
                send_item(cmd_item(tmse_pkg::ACT_STEP));
        end
        if ($urandom_range(99) < 25)
            send_item(cmd_item(tmse_pkg::ACT_STEP));
    endtask

    task automatic test_rule_scan();
        send_item(cmd_item(tmse_pkg::ACT_STEP));
        send_item(cmd_item(tmse_pkg::ACT_START));
        send_item(rule_item(4'd0, 3'd0, 1'b1, 8'h00, 1'b0, 8'h41,
                            tmse_pkg::DIR_STAY, 4'd0, 1'b0));
        send_item(rule_item(4'd0, 3'd2, 1'b0, 8'h20, 1'b0, 8'h61,
                            tmse_pkg::DIR_RIGHT, 4'd0, 1'b0));
        send_item(rule_item(4'd0, 3'd5, 1'b1, 8'hFF, 1'b1, 8'h00,
                            tmse_pkg::DIR_LEFT, 4'd0, 1'b0));
        // exact match in slot 2 wins over both wildcards
        send_item(cmd_item(tmse_pkg::ACT_STEP));
        send_item(cell_item(10'd0, 8'hFF));
        send_item(cell_item(10'd6, 8'h80));
        send_item(cell_item(10'd600, 8'h11));
        send_item(cmd_item(tmse_pkg::ACT_START));
        // last wildcard, keep, grows the tape on the left
        send_item(cmd_item(tmse_pkg::ACT_STEP));
    endtask

    task automatic test_halt_and_errors();
        send_item(rule_item(4'd1, 3'd7, 1'b0, 8'h7F, 1'b0, 8'h00,
                            tmse_pkg::DIR_BAD, 4'd1, 1'b0));
        send_item(rule_item(4'd0, 3'd1, 1'b0, 8'h20, 1'b0, 8'h7F,
                            tmse_pkg::DIR_STAY, 4'd1, 1'b0));
        send_item(cmd_item(tmse_pkg::ACT_STEP));
        send_item(cmd_item(tmse_pkg::ACT_STEP));
        send_item(cmd_item(tmse_pkg::ACT_STEP));
        send_item(rule_item(4'd3, 3'd0, 1'b0, 8'h00, 1'b0, 8'hAA,
                            tmse_pkg::DIR_RIGHT, 4'd15, 1'b1));
        send_item(rule_item(4'd3, 3'd1, 1'b1, 8'h00, 1'b1, 8'h00,
                            tmse_pkg::DIR_LEFT, 4'd14, 1'b0));
        set_config(4'd3, 10'd512, 8'd32);
        send_item(cmd_item(tmse_pkg::ACT_START));
        send_item(cmd_item(tmse_pkg::ACT_STEP));
        send_item(cell_item(10'd0, 8'h00));
        send_item(cmd_item(tmse_pkg::ACT_START));
        send_item(cmd_item(tmse_pkg::ACT_STEP));
        send_item(cmd_item(tmse_pkg::ACT_STEP));
    endtask

    task automatic test_tape_left_end();
        set_config(4'd4, 10'd0, 8'd0);
        send_item(rule_item(4'd4, 3'd0, 1'b1, 8'h00, 1'b0, 8'hFE,
                            tmse_pkg::DIR_LEFT, 4'd4, 1'b0));
        send_item(cmd_item(tmse_pkg::ACT_START));
        send_item(cmd_item(tmse_pkg::ACT_STEP));
        // undefined next state overrides the bad direction
        send_item(rule_item(4'd4, 3'd3, 1'b0, 8'hFE, 1'b0, 8'h55,
                            tmse_pkg::DIR_BAD, 4'd13, 1'b0));
        send_item(cmd_item(tmse_pkg::ACT_START));
        send_item(cmd_item(tmse_pkg::ACT_STEP));
    endtask

    task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct,
                                       input logic [3:0] init, input logic [9:0] origin,
                                       input logic [7:0] blank);
        int goal;
        goal = items_sent + n;
        set_config(init, origin, blank);
        set_idling(send_pct, recv_pct);
        while (items_sent < goal)
            run_program();
    endtask

    task automatic test_output_hold();
        set_idling(0, 0);
        fork
            hold_results(400);
            repeat (2) run_program();
        join
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= hold_out || ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        tm_status_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_status.size() == 0)
                    report_mismatch("result transfer with nothing pending");
                else
                begin
                    want = pending_status.pop_front();
                    if (current_state_out !== want.state)
                        report_mismatch($sformatf("state %0d, want %0d",
                                                  current_state_out, want.state));
                    if (head_offset !== want.offset)
                        report_mismatch($sformatf("head_offset %0d, want %0d",
                                                  head_offset, want.offset));
                    if (symbol_under_head !== want.symbol)
                        report_mismatch($sformatf("symbol 0x%0h, want 0x%0h",
                                                  symbol_under_head, want.symbol));
                    if (tape_length !== want.length)
                        report_mismatch($sformatf("tape_length %0d, want %0d",
                                                  tape_length, want.length));
                    if (halted !== want.halted)
                        report_mismatch($sformatf("halted %0b, want %0b",
                                                  halted, want.halted));
                    if (error_code !== want.err)
                        report_mismatch($sformatf("error_code %0d, want %0d",
                                                  error_code, want.err));
                end
            end
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= tmse_pkg::ACT_LOAD_RULE;
        rule_state   <= '0;
        rule_slot    <= '0;
        match_symbol <= '0;
        match_any    <= 1'b0;
        put_symbol   <= '0;
        put_keep     <= 1'b0;
        direction    <= tmse_pkg::DIR_RIGHT;
        next_state   <= '0;
        next_halts   <= 1'b0;
        cell_index   <= '0;
        cell_symbol  <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= tmse_pkg::CFG_INIT_STATE;
        cfg_data     <= '0;
        reset_machine();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rule_scan();
        test_halt_and_errors();
        test_tape_left_end();
        test_random_traffic(260, 0, 0, 4'd0, 10'd512, 8'd32);
        test_random_traffic(260, 65, 0, 4'd15, 10'd0, 8'd255);
        test_random_traffic(230, 27, 27, 4'($urandom_range(0, 12)),
                            10'($urandom_range(0, 1023)), 8'($urandom));
        test_output_hold();
        test_random_traffic(230, 0, 65, 4'd7, 10'd1023, 8'd0);

        settle_results(30);
        if (pending_status.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_status.size()));
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
